// File: design/dndc_pkg.sv
// ----------------------------------------------------------------------------
// Day number and date converter package
// Request types, calendar constants and month tables shared by the converter.
// ----------------------------------------------------------------------------
package dndc_pkg;

  localparam logic [15:0] LastDayNumber = 16'd47481;
  localparam logic [11:0] FirstYear     = 12'd1970;
  localparam logic [11:0] LastYear      = 12'd2099;
  localparam logic [11:0] BaseYear      = 12'd1969;
  localparam logic [8:0]  DaysPerYear   = 9'd365;
  localparam logic [10:0] DaysPerCycle  = 11'd1461;
  localparam logic [10:0] LeapLastRem   = 11'd1460;
  localparam logic [8:0]  LeapLastDoy   = 9'd365;
  localparam logic [15:0] EpochWeekday  = 16'd4;
  localparam logic [2:0]  DaysPerWeek   = 3'd7;
  localparam logic [15:0] CycleRecip    = 16'd45933;
  localparam int unsigned CycleShift    = 26;
  localparam logic [16:0] WeekRecip     = 17'd74898;
  localparam int unsigned WeekShift     = 19;
  localparam logic [3:0]  MonthJan      = 4'd1;
  localparam logic [3:0]  MonthFeb      = 4'd2;
  localparam logic [3:0]  MonthDec      = 4'd12;

  typedef enum logic {
    ModeDecode = 1'b0,
    ModeEncode = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] day_number_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] day_number_out;
    logic        valid_res;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        leap_year;
  } out_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] day_num;
    logic [11:0] year_echo;
  } enc_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] day_num;
    logic [11:0] year_echo;
    logic [5:0]  cycle;
    logic [10:0] rem;
    logic [2:0]  weekday;
  } div_t;

  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] start;
    unique case (month)
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd2:                     len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:       len = 5'd31;
      default:                  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/dndc_encode.sv
// ----------------------------------------------------------------------------
// Converter front stage
// Checks the request and turns an encode request into a day number.
// ----------------------------------------------------------------------------
module dndc_encode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  dndc_pkg::in_req_t req_i,
  output logic              valid_o,
  input  logic              stall_i,
  output dndc_pkg::enc_t    enc_o
);
  import dndc_pkg::*;

  logic        vld_q;
  logic        en;
  enc_t        enc_d, enc_q;
  logic        y_ok, m_ok, d_ok, leap;
  logic [4:0]  mlen;
  logic [7:0]  yoff;
  logic [16:0] num;

  assign en      = !vld_q || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q;
  assign enc_o   = enc_q;

  always_comb begin
    y_ok = (req_i.year_in >= FirstYear) && (req_i.year_in <= LastYear);
    m_ok = (req_i.month_in >= MonthJan) && (req_i.month_in <= MonthDec);
    leap = (req_i.year_in[1:0] == 2'b00);
    mlen = month_len(req_i.month_in) + {4'd0, (req_i.month_in == MonthFeb) && leap};
    d_ok = (req_i.day_in != 5'd0) && (req_i.day_in <= mlen);
    yoff = 8'(req_i.year_in - FirstYear);
    num  = 17'(yoff) * 17'(DaysPerYear)
         + 17'((req_i.year_in - BaseYear) >> 2)
         + 17'(month_start(req_i.month_in))
         + 17'(leap && (req_i.month_in > MonthFeb))
         + 17'(req_i.day_in) - 17'd1;
    if (req_i.mode == ModeDecode) begin
      enc_d.ok        = (req_i.day_number_in <= LastDayNumber);
      enc_d.day_num   = enc_d.ok ? req_i.day_number_in : 16'd0;
      enc_d.year_echo = 12'd0;
    end else begin
      enc_d.ok        = y_ok && m_ok && d_ok;
      enc_d.day_num   = enc_d.ok ? num[15:0] : 16'd0;
      enc_d.year_echo = enc_d.ok ? 12'd0 : req_i.year_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      enc_q <= enc_d;
    end
  end

endmodule

// File: design/dndc_divide.sv
// ----------------------------------------------------------------------------
// Converter divide stages
// Splits the day number into four-year cycles and weekday by reciprocal
// multiplication in one stage and remainder correction in the next.
// ----------------------------------------------------------------------------
module dndc_divide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  dndc_pkg::enc_t enc_i,
  output logic           valid_o,
  input  logic           stall_i,
  output dndc_pkg::div_t div_o
);
  import dndc_pkg::*;

  typedef struct packed {
    enc_t        enc;
    logic [15:0] t;
    logic [5:0]  qc;
    logic [15:0] w;
    logic [12:0] qw;
  } est_t;

  logic        a_vld_q, b_vld_q;
  logic        en_a, en_b;
  est_t        a_d, a_q;
  div_t        b_d, b_q;
  logic [31:0] prod_c;
  logic [32:0] prod_w;
  logic [16:0] qc_mul;
  logic [11:0] rc;
  logic [15:0] qw_mul;
  logic [3:0]  wr;

  assign en_b    = !b_vld_q || !stall_i;
  assign en_a    = !a_vld_q || en_b;
  assign stall_o = !en_a;
  assign valid_o = b_vld_q;
  assign div_o   = b_q;

  always_comb begin
    a_d.enc = enc_i;
    a_d.t   = enc_i.day_num + 16'(DaysPerYear);
    a_d.w   = enc_i.day_num + EpochWeekday;
    prod_c  = 32'(a_d.t) * 32'(CycleRecip);
    prod_w  = 33'(a_d.w) * 33'(WeekRecip);
    a_d.qc  = 6'(prod_c >> CycleShift);
    a_d.qw  = 13'(prod_w >> WeekShift);
  end

  always_comb begin
    qc_mul        = 17'(a_q.qc) * 17'(DaysPerCycle);
    rc            = 12'({1'b0, a_q.t} - qc_mul);
    qw_mul        = 16'(a_q.qw) * 16'(DaysPerWeek);
    wr            = 4'(a_q.w - qw_mul);
    b_d.ok        = a_q.enc.ok;
    b_d.day_num   = a_q.enc.day_num;
    b_d.year_echo = a_q.enc.year_echo;
    if (rc >= 12'(DaysPerCycle)) begin
      b_d.rem   = 11'(rc - 12'(DaysPerCycle));
      b_d.cycle = a_q.qc + 6'd1;
    end else begin
      b_d.rem   = rc[10:0];
      b_d.cycle = a_q.qc;
    end
    if (wr >= 4'(DaysPerWeek)) begin
      b_d.weekday = 3'(wr - 4'(DaysPerWeek));
    end else begin
      b_d.weekday = wr[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_vld_q <= valid_i;
      end
      if (en_b) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_q <= a_d;
    end
    if (en_b) begin
      b_q <= b_d;
    end
  end

endmodule

// File: design/dndc_calendar.sv
// ----------------------------------------------------------------------------
// Converter calendar stages
// Derives year and day of year, then month, then day of month, and holds
// the finished result in the output register.
// ----------------------------------------------------------------------------
module dndc_calendar (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  dndc_pkg::div_t     div_i,
  output logic               valid_o,
  input  logic               stall_i,
  output dndc_pkg::out_req_t res_o
);
  import dndc_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [15:0] day_num;
    logic [11:0] year_echo;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [8:0]  doy;
    logic        leap;
  } yr_t;

  typedef struct packed {
    yr_t        yr;
    logic [3:0] month;
  } mo_t;

  logic       y_vld_q, m_vld_q, o_vld_q;
  logic       en_y, en_m, en_o;
  yr_t        y_d, y_q;
  mo_t        m_d, m_q;
  out_req_t   o_d, o_q;
  logic [1:0] yi;
  logic [3:0] cnt;
  logic [8:0] start;

  assign en_o    = !o_vld_q || !stall_i;
  assign en_m    = !m_vld_q || en_o;
  assign en_y    = !y_vld_q || en_m;
  assign stall_o = !en_y;
  assign valid_o = o_vld_q;
  assign res_o   = o_q;

  always_comb begin
    y_d.ok        = div_i.ok;
    y_d.day_num   = div_i.day_num;
    y_d.year_echo = div_i.year_echo;
    y_d.weekday   = div_i.weekday;
    priority if (div_i.rem == LeapLastRem) begin
      yi      = 2'd3;
      y_d.doy = LeapLastDoy;
    end else if (div_i.rem >= 11'(3 * DaysPerYear)) begin
      yi      = 2'd3;
      y_d.doy = 9'(div_i.rem - 11'(3 * DaysPerYear));
    end else if (div_i.rem >= 11'(2 * DaysPerYear)) begin
      yi      = 2'd2;
      y_d.doy = 9'(div_i.rem - 11'(2 * DaysPerYear));
    end else if (div_i.rem >= 11'(DaysPerYear)) begin
      yi      = 2'd1;
      y_d.doy = 9'(div_i.rem - 11'(DaysPerYear));
    end else begin
      yi      = 2'd0;
      y_d.doy = div_i.rem[8:0];
    end
    y_d.leap = (yi == 2'd3);
    y_d.year = BaseYear + {4'd0, div_i.cycle, 2'b00} + {10'd0, yi};
  end

  always_comb begin
    cnt = 4'd0;
    for (int k = 2; k <= 12; k++) begin
      if (y_q.doy >= month_start(4'(k)) + {8'd0, y_q.leap && (k > 2)}) begin
        cnt = cnt + 4'd1;
      end
    end
    m_d.yr    = y_q;
    m_d.month = MonthJan + cnt;
  end

  always_comb begin
    start = month_start(m_q.month) + {8'd0, m_q.yr.leap && (m_q.month > MonthFeb)};
    o_d   = '0;
    if (m_q.yr.ok) begin
      o_d.day_number_out = m_q.yr.day_num;
      o_d.valid_res      = 1'b1;
      o_d.year_out       = m_q.yr.year;
      o_d.month_out      = m_q.month;
      o_d.day_out        = 5'(m_q.yr.doy + 9'd1 - start);
      o_d.weekday        = m_q.yr.weekday;
      o_d.day_of_year    = m_q.yr.doy;
      o_d.leap_year      = m_q.yr.leap;
    end else begin
      o_d.year_out       = m_q.yr.year_echo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (en_y) begin
        y_vld_q <= valid_i;
      end
      if (en_m) begin
        m_vld_q <= y_vld_q;
      end
      if (en_o) begin
        o_vld_q <= m_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_y) begin
      y_q <= y_d;
    end
    if (en_m) begin
      m_q <= m_d;
    end
    if (en_o) begin
      o_q <= o_d;
    end
  end

endmodule

// File: design/day_number_date_converter_unit.sv
// ----------------------------------------------------------------------------
// Day number and date converter
// Converts between days since 1 Jan 1970 and a civil date for 1970 to 2099.
// ----------------------------------------------------------------------------
// A request either decodes a day number into year, month, day of month,
// weekday, day of year and leap flag, or checks a date and encodes it into a
// day number that is then decoded the same way. The unit is a six-stage
// pipeline: request check and encode, reciprocal multiply, remainder
// correction, year split, month search, and day of month with the output
// register. It accepts one request per cycle when the output is not stalled;
// a stall holds the output register and each full stage in an unbroken run
// behind it, while empty stages keep filling, so nothing is lost or repeated.
module day_number_date_converter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dndc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dndc_pkg::out_req_t out_req_o
);
  import dndc_pkg::*;

  logic enc_valid, enc_stall;
  logic div_valid, div_stall;
  enc_t enc;
  div_t div;

  dndc_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .req_i   (in_req_i),
    .valid_o (enc_valid),
    .stall_i (enc_stall),
    .enc_o   (enc)
  );

  dndc_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (enc_valid),
    .stall_o (enc_stall),
    .enc_i   (enc),
    .valid_o (div_valid),
    .stall_i (div_stall),
    .div_o   (div)
  );

  dndc_calendar u_calendar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .stall_o (div_stall),
    .div_i   (div),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_req_o)
  );

endmodule

// File: design/dndc_checker.sv
// ----------------------------------------------------------------------------
// Day number and date converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module dndc_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dndc_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dndc_pkg::out_req_t out_req_o
);
  import dndc_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_req_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("Stalled result changed.");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the output register is empty.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.valid_res |->
      out_req_o.day_number_out == 16'd0 && out_req_o.month_out == 4'd0 &&
      out_req_o.day_out == 5'd0 && out_req_o.weekday == 3'd0 &&
      out_req_o.day_of_year == 9'd0 && !out_req_o.leap_year)
    else $error("Invalid result carries nonzero fields.");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.valid_res |->
      out_req_o.month_out >= MonthJan && out_req_o.month_out <= MonthDec &&
      out_req_o.day_out != 5'd0 && out_req_o.weekday < DaysPerWeek &&
      out_req_o.leap_year == (out_req_o.year_out[1:0] == 2'b00))
    else $error("Valid result outside the calendar.");

endmodule

bind day_number_date_converter_unit dndc_port_checker u_dndc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
